@@ src/neb_pkg.sv @@
package neb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int DEPTH_BITS = 16;
  localparam int PIX_W      = 24 + DEPTH_BITS;
  localparam int WEIGHT_W   = 17;
  localparam int GAIN_W     = 16;
  localparam int BETA_W     = 32;
  localparam int EXP_W      = 17;
  localparam int EXP_INT_LIMIT = 12;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SMOOTH_MODE = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd1;
  localparam logic [2:0] REG_COLOR_BETA  = 3'd2;
  localparam logic [2:0] REG_DEPTH_BETA  = 3'd3;
  localparam logic [2:0] REG_SMOOTH_GAIN = 3'd4;

  // Smoothing modes.
  localparam logic [1:0] MODE_COLOR = 2'd0;
  localparam logic [1:0] MODE_DEPTH = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;

  // Edge order inside a job and a result.
  localparam int EDGE_LEFT    = 0;
  localparam int EDGE_UPLEFT  = 1;
  localparam int EDGE_UP      = 2;
  localparam int EDGE_UPRIGHT = 3;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [1:0]         smooth_mode;
    logic [WIDTH_W-1:0] image_width;
    logic [BETA_W-1:0]  color_beta;
    logic [BETA_W-1:0]  depth_beta;
    logic [GAIN_W-1:0]  smooth_gain;
  } cfg_t;

  // One classified pixel: the pixel itself, its four neighbors and which exist.
  typedef struct packed {
    pixel_t       cur;
    pixel_t [3:0] nb;
    logic   [3:0] present;
    logic         dvalid;
  } job_t;

  // exp(-k/32) in Q16.
  function automatic logic [EXP_W-1:0] expf_lut(input logic [4:0] k);
    logic [EXP_W-1:0] v;
    unique case (k)
      5'd0:  v = 17'd65536; 5'd1:  v = 17'd63520; 5'd2:  v = 17'd61565;
      5'd3:  v = 17'd59671; 5'd4:  v = 17'd57835; 5'd5:  v = 17'd56056;
      5'd6:  v = 17'd54331; 5'd7:  v = 17'd52660; 5'd8:  v = 17'd51039;
      5'd9:  v = 17'd49469; 5'd10: v = 17'd47947; 5'd11: v = 17'd46472;
      5'd12: v = 17'd45042; 5'd13: v = 17'd43656; 5'd14: v = 17'd42313;
      5'd15: v = 17'd41011; 5'd16: v = 17'd39750; 5'd17: v = 17'd38527;
      5'd18: v = 17'd37341; 5'd19: v = 17'd36192; 5'd20: v = 17'd35079;
      5'd21: v = 17'd34000; 5'd22: v = 17'd32954; 5'd23: v = 17'd31940;
      5'd24: v = 17'd30957; 5'd25: v = 17'd30005; 5'd26: v = 17'd29081;
      5'd27: v = 17'd28187; 5'd28: v = 17'd27319; 5'd29: v = 17'd26479;
      5'd30: v = 17'd25664; 5'd31: v = 17'd24875;
      default: v = '0;
    endcase
    return v;
  endfunction

  // exp(-i) in Q16 for i below EXP_INT_LIMIT.
  function automatic logic [EXP_W-1:0] expi_lut(input logic [3:0] i);
    logic [EXP_W-1:0] v;
    unique case (i)
      4'd0:  v = 17'd65536; 4'd1: v = 17'd24109; 4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;  4'd4: v = 17'd1200;  4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;   4'd7: v = 17'd60;    4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;     4'd10: v = 17'd3;    4'd11: v = 17'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/neighbor_edge_weights.sv @@
// Graph-cut edge weights for an 8-connected pixel grid. Pixels are pushed in
// raster order (RGB, depth and a depth-valid flag, with frame_start on the
// first pixel of a frame) and one item comes out per pixel, holding the
// weights toward the left, up-left, up and up-right neighbors in unsigned
// Q9.8. Each weight is gain * exp(-beta * d2), with d2 the squared color
// distance or squared depth difference (both terms summed in MODE_BOTH);
// diagonal edges use gain / sqrt(2), and edges to neighbors outside the
// image are zero. A front stage tracks the raster position and keeps the
// previous row in a 1024-entry line memory, read as a pixel is accepted and
// written back in F_READ, when no pixel is taken. A two-entry queue hands
// classified pixels to the back stage, which runs all eight color and depth
// terms through one shared five-stage exponential pipeline, taking no new
// pixel until its result is queued. Results wait in a two-entry output
// queue. Configuration registers may only be written while the block holds
// no pixel in flight; the cfg port is always ready.
module neighbor_edge_weights (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic [15:0]                  in_depth,
  input  logic                         in_depth_valid,
  input  logic                         in_frame_start,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [neb_pkg::WEIGHT_W-1:0] out_left_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_upleft_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_up_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_upright_weight
);
  import neb_pkg::*;

  cfg_t       cfg_r;
  job_t       front_job;
  job_t       queue_job;
  logic       job_push;
  logic       job_full;
  logic       job_pop;
  logic       job_empty;
  logic [1:0] job_count;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_mode <= MODE_COLOR;
      cfg_r.image_width <= WIDTH_W'(640);
      cfg_r.color_beta  <= '0;
      cfg_r.depth_beta  <= '0;
      cfg_r.smooth_gain <= GAIN_W'(12800);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMOOTH_MODE: cfg_r.smooth_mode <= cfg_data[1:0];
        REG_IMAGE_WIDTH: cfg_r.image_width <= cfg_data[WIDTH_W-1:0];
        REG_COLOR_BETA:  cfg_r.color_beta  <= cfg_data;
        REG_DEPTH_BETA:  cfg_r.depth_beta  <= cfg_data;
        REG_SMOOTH_GAIN: cfg_r.smooth_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  neb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .image_width    (cfg_r.image_width),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_depth       (in_depth),
    .in_depth_valid (in_depth_valid),
    .in_frame_start (in_frame_start),
    .job_push       (job_push),
    .job            (front_job),
    .job_full       (job_full)
  );

  neb_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (queue_job),
    .empty    (job_empty),
    .count    (job_count)
  );

  neb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .job                (queue_job),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .out_left_weight    (out_left_weight),
    .out_upleft_weight  (out_upleft_weight),
    .out_up_weight      (out_up_weight),
    .out_upright_weight (out_upright_weight),
    .out_empty          (out_empty),
    .out_pop            (out_pop)
  );

  // The front only hands over a pixel when the queue has room for it.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("front pushed into a full job queue");

  // The back only takes a pixel that is really waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("back popped an empty job queue");

  // The queue never holds more than its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_count != 2'd3)
    else $error("job queue count out of range");

  // Accepting a pixel makes the input side busy for the next cycle.
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front accepted two pixels back to back");

endmodule

@@ src/neb_front.sv @@
module neb_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [neb_pkg::WIDTH_W-1:0] image_width,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [15:0]                 in_depth,
  input  logic                        in_depth_valid,
  input  logic                        in_frame_start,
  output logic                        job_push,
  output neb_pkg::job_t               job,
  input  logic                        job_full
);
  import neb_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_READ = 1'b1;

  logic               state_r;
  logic [COL_W-1:0]   col_r;
  logic               first_r;
  pixel_t             left_r;
  pixel_t             prev_up_r;
  pixel_t             row_store [MAX_WIDTH];
  pixel_t             up_rd_r;
  pixel_t             ur_rd_r;
  pixel_t             cur_r;
  logic [COL_W-1:0]   x_r;
  logic               fr_r;
  logic               dvalid_r;

  logic [WIDTH_W-1:0] w_eff;
  logic               accept;
  logic [COL_W-1:0]   x0;
  logic               fr0;
  logic [WIDTH_W-1:0] xp1;
  logic               row_end;
  pixel_t             cur_in;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  assign in_full = (state_r != F_IDLE) || job_full;
  assign accept  = in_push && !in_full;
  assign cur_in  = {in_depth[DEPTH_BITS-1:0], in_blue, in_green, in_red};

  // A frame start forces column 0 of the first row; a shrunken width wraps.
  always_comb begin
    x0  = in_frame_start ? '0 : col_r;
    fr0 = in_frame_start ? 1'b1 : first_r;
    if ({1'b0, x0} >= w_eff) begin
      x0  = '0;
      fr0 = 1'b0;
    end
  end

  assign xp1     = {1'b0, x_r} + WIDTH_W'(1);
  assign row_end = xp1 >= w_eff;

  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r  <= row_store[x0];
      ur_rd_r  <= row_store[x0 + COL_W'(1)];
      cur_r    <= cur_in;
      x_r      <= x0;
      fr_r     <= fr0;
      dvalid_r <= in_depth_valid;
    end
    if (state_r == F_READ) begin
      row_store[x_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      col_r     <= '0;
      first_r   <= 1'b1;
      left_r    <= '0;
      prev_up_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_READ;
          end
        end
        F_READ: begin
          state_r   <= F_IDLE;
          left_r    <= cur_r;
          prev_up_r <= up_rd_r;
          col_r     <= row_end ? '0 : xp1[COL_W-1:0];
          first_r   <= row_end ? 1'b0 : fr_r;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign job_push = (state_r == F_READ);

  always_comb begin
    job.cur                   = cur_r;
    job.nb[EDGE_LEFT]         = left_r;
    job.nb[EDGE_UPLEFT]       = prev_up_r;
    job.nb[EDGE_UP]           = up_rd_r;
    job.nb[EDGE_UPRIGHT]      = ur_rd_r;
    job.present[EDGE_LEFT]    = x_r != '0;
    job.present[EDGE_UPLEFT]  = (x_r != '0) && !fr_r;
    job.present[EDGE_UP]      = !fr_r;
    job.present[EDGE_UPRIGHT] = !fr_r && !row_end;
    job.dvalid                = dvalid_r;
  end

endmodule

@@ src/neb_job_queue.sv @@
module neb_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  neb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output neb_pkg::job_t pop_job,
  output logic          empty,
  output logic [1:0]    count
);
  import neb_pkg::*;

  job_t       slot_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign count   = cnt_r;
  assign pop_job = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ src/neb_back.sv @@
module neb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  neb_pkg::cfg_t                cfg,
  input  neb_pkg::job_t                job,
  input  logic                         job_empty,
  output logic                         job_pop,
  output logic [neb_pkg::WEIGHT_W-1:0] out_left_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_upleft_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_up_weight,
  output logic [neb_pkg::WEIGHT_W-1:0] out_upright_weight,
  output logic                         out_empty,
  input  logic                         out_pop
);
  import neb_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RUN   = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  typedef struct packed {
    logic              vld;
    logic              en;
    logic [GAIN_W-1:0] gain;
    logic [2:0]        term;
  } term_ctl_t;

  typedef logic [WEIGHT_W-1:0] weight_t;

  logic [1:0]         state_r;
  logic [2:0]         cnt_r;
  job_t               job_r;
  weight_t            acc_r [4];

  term_ctl_t          c1_r, c2_r, c3_r, c4_r;
  logic [31:0]        d2_r;
  logic [BETA_W-1:0]  beta_r;
  logic [63:0]        x_r;
  logic [EXP_W-1:0]   expf_r;
  logic [11:0]        phi_r;
  logic [3:0]         idx_r;
  logic               sat_r;
  logic [EXP_W-1:0]   e_r;

  weight_t            ofifo_r [2][4];
  logic               owptr_r;
  logic               orptr_r;
  logic [1:0]         ocnt_r;

  logic               start;
  logic [1:0]         edge_sel;
  logic               is_depth;
  pixel_t             nb;
  logic [7:0]         dr, dg, db;
  logic [17:0]        cd2;
  logic [15:0]        dd;
  logic [31:0]        dd2;
  logic               use_color;
  logic               use_depth;
  logic [31:0]        gd_prod;
  term_ctl_t          c0;
  logic [43:0]        fprod;
  logic [EXP_W-1:0]   b;
  logic [33:0]        eprod;
  logic [32:0]        wprod;
  weight_t            w;
  logic               ofull;
  logic               opop;
  logic               opush;

  assign ofull = ocnt_r == 2'd2;
  assign start = (state_r == B_IDLE) && !job_empty && !ofull;
  assign job_pop = start;

  // Term t handles edge t/2, color when t is even and depth when odd.
  assign edge_sel = cnt_r[2:1];
  assign is_depth = cnt_r[0];
  assign nb       = job_r.nb[edge_sel];

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] c);
    return (a > c) ? a - c : c - a;
  endfunction

  always_comb begin
    dr  = absdiff8(job_r.cur[7:0], nb[7:0]);
    dg  = absdiff8(job_r.cur[15:8], nb[15:8]);
    db  = absdiff8(job_r.cur[23:16], nb[23:16]);
    cd2 = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
    dd  = (job_r.cur[PIX_W-1:24] > nb[PIX_W-1:24]) ?
          16'(job_r.cur[PIX_W-1:24] - nb[PIX_W-1:24]) :
          16'(nb[PIX_W-1:24] - job_r.cur[PIX_W-1:24]);
    dd2 = dd * dd;
    use_color = (cfg.smooth_mode == MODE_COLOR) || (cfg.smooth_mode == MODE_BOTH);
    use_depth = ((cfg.smooth_mode == MODE_DEPTH) || (cfg.smooth_mode == MODE_BOTH))
                && job_r.dvalid;
    gd_prod = cfg.smooth_gain * INV_SQRT2_Q16;
    c0.vld  = state_r == B_RUN;
    c0.en   = job_r.present[edge_sel] && (is_depth ? use_depth : use_color);
    c0.gain = edge_sel[0] ? gd_prod[31:16] : cfg.smooth_gain;
    c0.term = cnt_r;
  end

  // Exponential pipeline: d2, product with beta, fraction, integer part, gain.
  // The fraction correction is taken from the same product as the table entry.
  always_comb begin
    fprod = expf_lut(x_r[31:27]) * x_r[26:0];
    b     = expf_r - EXP_W'(phi_r);
    eprod = expi_lut(idx_r) * b;
    wprod = c4_r.gain * e_r;
    w     = WEIGHT_W'(wprod[32:16]);
  end

  always_ff @(posedge clk) begin
    d2_r   <= is_depth ? dd2 : 32'(cd2);
    beta_r <= is_depth ? cfg.depth_beta : cfg.color_beta;
    x_r    <= d2_r * beta_r;
    expf_r <= expf_lut(x_r[31:27]);
    phi_r  <= 12'(fprod[43:32]);
    idx_r  <= x_r[35:32];
    sat_r  <= x_r[63:32] >= 32'(EXP_INT_LIMIT);
    e_r    <= (sat_r || !c3_r.en) ? '0 : EXP_W'(eprod[32:16]);
    if (start) begin
      job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
    end else begin
      c1_r <= c0;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
      unique case (state_r)
        B_IDLE: begin
          if (start) begin
            state_r <= B_RUN;
            cnt_r   <= '0;
          end
        end
        B_RUN: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (c4_r.vld && c4_r.term == 3'd7) begin
            state_r <= B_DONE;
          end
        end
        B_DONE:  state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else if (c4_r.vld) begin
      acc_r[c4_r.term[2:1]] <= acc_r[c4_r.term[2:1]] + w;
    end
  end

  // Result queue: the next pixel is worked on while a result waits.
  assign opush     = state_r == B_DONE;
  assign opop      = out_pop && !out_empty;
  assign out_empty = ocnt_r == 2'd0;

  assign out_left_weight    = ofifo_r[orptr_r][EDGE_LEFT];
  assign out_upleft_weight  = ofifo_r[orptr_r][EDGE_UPLEFT];
  assign out_up_weight      = ofifo_r[orptr_r][EDGE_UP];
  assign out_upright_weight = ofifo_r[orptr_r][EDGE_UPRIGHT];

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo_r[owptr_r] <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      if (opush) begin
        owptr_r <= !owptr_r;
      end
      if (opop) begin
        orptr_r <= !orptr_r;
      end
      ocnt_r <= ocnt_r + 2'(opush) - 2'(opop);
    end
  end

endmodule

@@ bench/neighbor_edge_weights_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the graph-cut edge weight block. Pixels are pushed
// in raster order through the push port, and every item popped from the
// output queue is compared field by field with a typed expectation or with
// a weight predictor with its own line memory, raster position and registers.
module neighbor_edge_weights_tb;
  import neb_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int RANDOM_PIXELS = 1200;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_SMOOTH_MODE;
  logic [31:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic [15:0] in_depth = '0;
  logic in_depth_valid = 1'b0, in_frame_start = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [WEIGHT_W-1:0] out_left_weight, out_upleft_weight, out_up_weight;
  logic [WEIGHT_W-1:0] out_upright_weight;

  always #5 clk = ~clk;

  neighbor_edge_weights u_dut (.*);

  typedef struct packed {
    logic [WEIGHT_W-1:0] left_w;
    logic [WEIGHT_W-1:0] upleft_w;
    logic [WEIGHT_W-1:0] up_w;
    logic [WEIGHT_W-1:0] upright_w;
  } weights_t;

  typedef struct {
    logic [7:0]  r, g, b;
    logic [15:0] d;
    logic        dv, fs;
    logic        known;   // expected weights typed into the row
    weights_t    w;
  } pixel_row_t;

  // Predictor copy of the registers and raster state.
  logic [1:0]        m_mode;
  logic [WIDTH_W-1:0] m_width;
  logic [31:0]       m_cbeta, m_dbeta;
  logic [15:0]       m_gain;
  pixel_t            m_line [MAX_WIDTH];
  pixel_t            m_left;
  pixel_t            m_upleft;
  int unsigned       m_col;
  bit                m_first;

  weights_t expected_weights[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int stall_chance = 20;
  int pop_hold = 0;

  // Bounded exp(-beta*d2) in Q16, saturating to zero.
  function automatic logic [63:0] exp_q16(logic [31:0] beta, logic [63:0] d2);
    logic [127:0] x;
    logic [63:0] i, k, r, f, b;
    logic [63:0] expf_tab [32] = '{65536, 63520, 61565, 59671, 57835, 56056, 54331,
      52660, 51039, 49469, 47947, 46472, 45042, 43656, 42313, 41011, 39750, 38527,
      37341, 36192, 35079, 34000, 32954, 31940, 30957, 30005, 29081, 28187, 27319,
      26479, 25664, 24875};
    logic [63:0] expi_tab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
      8, 3, 1};
    x = beta * d2;
    if (x[127:64] != 0) return 0;
    i = x[63:32];
    if (i >= 12) return 0;
    k = x[31:27];
    r = x[26:0];
    f = expf_tab[k];
    b = f - ((f * r) >> 32);
    return (expi_tab[i] * b) >> 16;
  endfunction

  function automatic logic [WEIGHT_W-1:0] edge_w(pixel_t a, pixel_t n,
                                                 logic [63:0] g, bit dv);
    logic [63:0] cd, dd, da, db, w, diff;
    cd = 0;
    for (int c = 0; c < 3; c++) begin
      da = a[8*c +: 8];
      db = n[8*c +: 8];
      diff = (da > db) ? da - db : db - da;
      cd += diff * diff;
    end
    da = a[24 +: DEPTH_BITS];
    db = n[24 +: DEPTH_BITS];
    diff = (da > db) ? da - db : db - da;
    dd = diff * diff;
    w = 0;
    if (m_mode == MODE_COLOR || m_mode == MODE_BOTH)
      w += (g * exp_q16(m_cbeta, cd)) >> 16;
    if ((m_mode == MODE_DEPTH || m_mode == MODE_BOTH) && dv)
      w += (g * exp_q16(m_dbeta, dd)) >> 16;
    return w[WEIGHT_W-1:0];
  endfunction

  function automatic weights_t predict_weights(pixel_row_t p);
    int unsigned wd, x;
    pixel_t cur, up, ur;
    logic [63:0] gs, gd;
    bit has_left, has_up, has_ur;
    weights_t w;
    wd = (m_width == 0) ? 1 : (m_width > MAX_WIDTH ? MAX_WIDTH : m_width);
    if (p.fs) begin
      m_col = 0;
      m_first = 1;
    end
    if (m_col >= wd) begin
      m_col = 0;
      m_first = 0;
    end
    x = m_col;
    cur = {p.d, p.b, p.g, p.r};
    up = m_line[x];
    ur = (x + 1 < MAX_WIDTH) ? m_line[x + 1] : '0;
    has_left = x > 0;
    has_up = !m_first;
    has_ur = has_up && (x + 1 < wd);
    gs = m_gain;
    gd = (64'(m_gain) * 46341) >> 16;
    w.left_w    = has_left ? edge_w(cur, m_left, gs, p.dv) : '0;
    w.upleft_w  = (has_left && has_up) ? edge_w(cur, m_upleft, gd, p.dv) : '0;
    w.up_w      = has_up ? edge_w(cur, up, gs, p.dv) : '0;
    w.upright_w = has_ur ? edge_w(cur, ur, gd, p.dv) : '0;
    // The up-left neighbor of the next pixel is this pixel's upper neighbor.
    m_upleft = up;
    m_line[x] = cur;
    m_left = cur;
    m_col = x + 1;
    if (m_col >= wd) begin
      m_col = 0;
      m_first = 0;
    end
    return w;
  endfunction

  // Short gaps most of the time, a long one now and then.
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SMOOTH_MODE: m_mode  = val[1:0];
      REG_IMAGE_WIDTH: m_width = val[WIDTH_W-1:0];
      REG_COLOR_BETA:  m_cbeta = val;
      REG_DEPTH_BETA:  m_dbeta = val;
      REG_SMOOTH_GAIN: m_gain  = val[15:0];
      default: ;
    endcase
  endtask

  // Pushes one pixel; a typed expectation, when present, overrides the predicted weights.
  task automatic push_pixel(pixel_row_t p);
    weights_t w;
    if (stall_chance > 0 && $urandom_range(0, 99) < stall_chance) begin
      in_push <= 1'b0;
      random_gap();
    end
    in_push <= 1'b1;
    in_red <= p.r;
    in_green <= p.g;
    in_blue <= p.b;
    in_depth <= p.d;
    in_depth_valid <= p.dv;
    in_frame_start <= p.fs;
    do @(posedge clk); while (in_full);
    w = predict_weights(p);
    if (p.known) w = p.w;
    expected_weights = {expected_weights, w};
  endtask

  task automatic finish_phase();
    in_push <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pixel_row_t mk(int r, int g, int b, int d, bit dv, bit fs);
    pixel_row_t p;
    p.r = 8'(r); p.g = 8'(g); p.b = 8'(b); p.d = 16'(d); p.dv = dv; p.fs = fs;
    p.known = 0;
    p.w = '0;
    return p;
  endfunction

  function automatic pixel_row_t mkw(pixel_row_t p, int l, int ul, int u, int ur);
    p.known = 1;
    p.w = '{WEIGHT_W'(l), WEIGHT_W'(ul), WEIGHT_W'(u), WEIGHT_W'(ur)};
    return p;
  endfunction

  // Result side: pop with random stalls and compare every field.
  always @(posedge clk) begin
    weights_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_weights.size() == 0) begin
        $error("result with no pixel pending");
        errors++;
      end else begin
        e = expected_weights.pop_front();
        checked++;
        if (out_left_weight !== e.left_w) begin
          $error("left_weight expected %0d actual %0d", e.left_w, out_left_weight);
          errors++;
        end
        if (out_upleft_weight !== e.upleft_w) begin
          $error("upleft_weight expected %0d actual %0d", e.upleft_w, out_upleft_weight);
          errors++;
        end
        if (out_up_weight !== e.up_w) begin
          $error("up_weight expected %0d actual %0d", e.up_w, out_up_weight);
          errors++;
        end
        if (out_upright_weight !== e.upright_w) begin
          $error("upright_weight expected %0d actual %0d", e.upright_w,
                 out_upright_weight);
          errors++;
        end
      end
    end
    if (rst_n) begin
      // Mostly ready, with occasional long stalls on the result side.
      if (pop_hold > 0) begin
        pop_hold--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        pop_hold = $urandom_range(10, 40);
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) out_pop <= ~out_pop;
      else out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  pixel_row_t directed[$];
  int unsigned wd_cur;

  initial begin
    pixel_row_t p;
    m_mode = MODE_COLOR;
    m_width = 640;
    m_cbeta = 0;
    m_dbeta = 0;
    m_gain = 12800;
    foreach (m_line[i]) m_line[i] = '0;
    m_left = '0;
    m_upleft = '0;
    m_col = 0;
    m_first = 1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first pixel has no neighbors, so all weights are zero.
    push_pixel(mkw(mk(255, 0, 255, 65535, 1, 1), 0, 0, 0, 0));
    // With beta zero the present left edge carries the full gain (50.0).
    push_pixel(mkw(mk(0, 255, 0, 0, 0, 0), 12800, 0, 0, 0));
    finish_phase();

    // A 3-wide image exercises every edge position and both row ends.
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_COLOR_BETA, 32'h0000_1000);
    write_reg(REG_DEPTH_BETA, 32'h0000_0100);
    write_reg(REG_SMOOTH_GAIN, 16'hFFFF);
    for (int md = 0; md < 4; md++) begin
      write_reg(REG_SMOOTH_MODE, md);
      directed.delete();
      directed = {directed, mk(0, 0, 0, 0, 1, 1)};
      directed = {directed, mk(255, 255, 255, 65535, 1, 0)};
      directed = {directed, mk(10, 20, 30, 100, 0, 0)};
      directed = {directed, mk(12, 20, 29, 101, 1, 0)};
      directed = {directed, mk(255, 0, 0, 0, 1, 0)};
      directed = {directed, mk(10, 20, 30, 100, 1, 0)};
      directed = {directed, mk(0, 0, 0, 0, 0, 0)};
      foreach (directed[i]) push_pixel(directed[i]);
      finish_phase();
    end

    // Width 0 counts as 1; width above the line memory is clamped.
    write_reg(REG_SMOOTH_MODE, MODE_BOTH);
    write_reg(REG_IMAGE_WIDTH, 0);
    for (int i = 0; i < 4; i++) push_pixel(mk(i * 60, 3, 9, i * 7, 1, i == 0));
    finish_phase();
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_COLOR_BETA, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH_BETA, 0);
    write_reg(REG_SMOOTH_GAIN, 0);
    for (int i = 0; i < 3; i++) push_pixel(mk(i, 1, 2, 3, 1, i == 0));
    finish_phase();

    // Random frames with varied settings; most images are narrow.
    for (int ph = 0; ph < 12; ph++) begin
      wd_cur = (ph == 11) ? 1024 : $urandom_range(1, 12);
      if (ph == 10) wd_cur = 1025;
      write_reg(REG_IMAGE_WIDTH, wd_cur);
      write_reg(REG_SMOOTH_MODE, $urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: write_reg(REG_COLOR_BETA, $urandom);
        1: write_reg(REG_COLOR_BETA, $urandom_range(0, 32'h0100_0000));
        default: write_reg(REG_COLOR_BETA, $urandom_range(0, 32'h0000_8000));
      endcase
      write_reg(REG_DEPTH_BETA, ($urandom_range(0, 1)) ? $urandom
                                : $urandom_range(0, 32'h0000_0400));
      write_reg(REG_SMOOTH_GAIN, $urandom);
      stall_chance = (ph % 3 == 0) ? 0 : 20;
      for (int i = 0; i < RANDOM_PIXELS / 12; i++) begin
        p = mk($urandom, $urandom, $urandom, $urandom, 1'($urandom), i == 0);
        if (i != 0 && $urandom_range(0, 99) < 2) p.fs = 1;
        // Nearby values keep exponents away from saturation now and then.
        if ($urandom_range(0, 1)) begin
          p.r = 8'(128 + $urandom_range(0, 7));
          p.g = 8'(64 + $urandom_range(0, 7));
          p.d = 16'(1000 + $urandom_range(0, 15));
        end
        push_pixel(p);
      end
      finish_phase();
    end

    $display("checked %0d results over directed edge cases and 12 random frames",
             checked);
    $display("widths from 0 to 2047, all four modes, gains and betas at both ends");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
